[src/lpg_pkg.sv]
package lpg_pkg;

  // Width of every coordinate field on the channels
  localparam int unsigned FIELD_W = 6;

  // Default coordinate span in bits (a 64 by 64 grid)
  localparam int unsigned COORD_BITS_DEF = 6;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture a new line and set up the error term
    logic step;  // move the current pixel to the output and advance the walk
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;  // current pixel is the end point
  } status_t;

endpackage

[src/lpg_if.sv]
interface lpg_line_if;
  import lpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] start_x;
  logic [FIELD_W-1:0] start_y;
  logic [FIELD_W-1:0] end_x;
  logic [FIELD_W-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x, output end_y,
                  input ready);
  modport sink (input valid, input start_x, input start_y, input end_x, input end_y,
                output ready);
endinterface

interface lpg_pixel_if;
  import lpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] pixel_x;
  logic [FIELD_W-1:0] pixel_y;
  logic               last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input last_pixel,
                output ready);
endinterface

[src/lpg_ctrl.sv]
module lpg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             line_valid_i,
  output logic             line_ready_o,
  output logic             pixel_valid_o,
  input  logic             pixel_ready_i,
  input  lpg_pkg::status_t status_i,
  output lpg_pkg::cmd_t    cmd_o
);
  import lpg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  // Take a line only when no walk is running
  assign line_ready_o  = (state_q == ST_IDLE);
  assign pixel_valid_o = out_valid_q;

  // Advance the walk whenever the output register is free or being drained
  always_comb begin
    cmd.load = (state_q == ST_IDLE) && line_valid_i;
    cmd.step = (state_q == ST_WALK) && (!out_valid_q || pixel_ready_i);
  end
  assign cmd_o = cmd;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd.load) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (cmd.step && status_i.done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output word valid: set on a step, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.step) begin
      out_valid_d = 1'b1;
    end else if (pixel_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/lpg_dp.sv]
module lpg_dp #(
  parameter int unsigned CoordBits = lpg_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  lpg_pkg::cmd_t               cmd_i,
  output lpg_pkg::status_t            status_o,
  input  logic [lpg_pkg::FIELD_W-1:0] start_x_i,
  input  logic [lpg_pkg::FIELD_W-1:0] start_y_i,
  input  logic [lpg_pkg::FIELD_W-1:0] end_x_i,
  input  logic [lpg_pkg::FIELD_W-1:0] end_y_i,
  output logic [lpg_pkg::FIELD_W-1:0] pixel_x_o,
  output logic [lpg_pkg::FIELD_W-1:0] pixel_y_o,
  output logic                        last_pixel_o
);
  import lpg_pkg::*;

  // Error term is kept with headroom for the doubled value
  localparam int unsigned ErrW = CoordBits + 4;

  logic [CoordBits-1:0]   xs, ys, xe, ye;
  logic signed [CoordBits:0] dxs, dys;
  logic [CoordBits-1:0]   dxa, dya;

  logic [CoordBits-1:0]   x_q, y_q, xe_q, ye_q, dx_q, dy_q;
  logic                   sx_pos_q, sy_pos_q;
  logic signed [ErrW-1:0] err_q, err_d;
  logic [CoordBits-1:0]   x_d, y_d;

  logic [CoordBits-1:0]   px_q, py_q;
  logic                   plast_q;

  logic signed [ErrW-1:0] e2, dx_e, dy_e;
  logic                   move_x, move_y, done;

  // Wrap input coordinates into the span
  assign xs = start_x_i[CoordBits-1:0];
  assign ys = start_y_i[CoordBits-1:0];
  assign xe = end_x_i[CoordBits-1:0];
  assign ye = end_y_i[CoordBits-1:0];

  // Signed deltas and their magnitudes
  assign dxs = $signed({1'b0, xe}) - $signed({1'b0, xs});
  assign dys = $signed({1'b0, ye}) - $signed({1'b0, ys});
  assign dxa = dxs[CoordBits] ? CoordBits'(-dxs) : CoordBits'(dxs);
  assign dya = dys[CoordBits] ? CoordBits'(-dys) : CoordBits'(dys);

  // One Bresenham step from the current pixel
  assign dx_e   = $signed(ErrW'(dx_q));
  assign dy_e   = $signed(ErrW'(dy_q));
  assign e2     = err_q <<< 1;
  assign move_x = (e2 > -dy_e);
  assign move_y = (e2 < dx_e);
  assign done   = (x_q == xe_q) && (y_q == ye_q);

  always_comb begin
    err_d = err_q;
    x_d   = x_q;
    y_d   = y_q;
    if (move_x) begin
      err_d = err_d - dy_e;
      x_d   = sx_pos_q ? x_q + CoordBits'(1) : x_q - CoordBits'(1);
    end
    if (move_y) begin
      err_d = err_d + dx_e;
      y_d   = sy_pos_q ? y_q + CoordBits'(1) : y_q - CoordBits'(1);
    end
  end

  // Walk registers: load a new line or advance one pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q      <= xs;
      y_q      <= ys;
      xe_q     <= xe;
      ye_q     <= ye;
      dx_q     <= dxa;
      dy_q     <= dya;
      sx_pos_q <= !dxs[CoordBits] && (dxs != '0);
      sy_pos_q <= !dys[CoordBits] && (dys != '0);
      err_q    <= $signed(ErrW'(dxa)) - $signed(ErrW'(dya));
    end else if (cmd_i.step) begin
      x_q   <= x_d;
      y_q   <= y_d;
      err_q <= err_d;
    end
  end

  // Output register: hold the current pixel until the next step
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      px_q    <= x_q;
      py_q    <= y_q;
      plast_q <= done;
    end
  end

  assign status_o.done = done;
  assign pixel_x_o     = FIELD_W'(px_q);
  assign pixel_y_o     = FIELD_W'(py_q);
  assign last_pixel_o  = plast_q;

endmodule

[src/line_pixel_generator_core.sv]
// Accepting a line loads the walk registers and enters the walk state; the first step then
//   moves the start point into the output register. One pixel per cycle while the output
//   is drained; a line has N pixels (N = max(|dx|,|dy|)+1, up to 2^COORD_BITS), one per
//   step of the single-step error-term walk in the datapath.
// The next line is accepted once the end point is in the output register.
// Reset (rst_ni low, asynchronous) empties the output register and idles the walk.
module line_pixel_generator_core #(
  parameter int unsigned COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpg_line_if.sink    line_i,
  lpg_pixel_if.source pixel_o
);
  import lpg_pkg::*;

  cmd_t    cmd;
  status_t status;

  lpg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_valid_i  (line_i.valid),
    .line_ready_o  (line_i.ready),
    .pixel_valid_o (pixel_o.valid),
    .pixel_ready_i (pixel_o.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  lpg_dp #(
    .CoordBits (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .start_x_i    (line_i.start_x),
    .start_y_i    (line_i.start_y),
    .end_x_i      (line_i.end_x),
    .end_y_i      (line_i.end_y),
    .pixel_x_o    (pixel_o.pixel_x),
    .pixel_y_o    (pixel_o.pixel_y),
    .last_pixel_o (pixel_o.last_pixel)
  );

endmodule

[src/lpg_checker.sv]
module lpg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        line_valid_i,
  input logic                        line_ready_i,
  input logic [lpg_pkg::FIELD_W-1:0] start_x_i,
  input logic [lpg_pkg::FIELD_W-1:0] start_y_i,
  input logic                        pixel_valid_i,
  input logic                        pixel_ready_i,
  input logic [lpg_pkg::FIELD_W-1:0] pixel_x_i,
  input logic [lpg_pkg::FIELD_W-1:0] pixel_y_i,
  input logic                        last_pixel_i
);
  import lpg_pkg::*;

  logic               line_fire, pixel_fire;
  logic [1:0]         open_q, open_d;
  logic               first_q, first_d;
  logic [FIELD_W-1:0] sx_q, sy_q;

  assign line_fire  = line_valid_i && line_ready_i;
  assign pixel_fire = pixel_valid_i && pixel_ready_i;

  // Count lines whose end point has not been delivered yet
  always_comb begin
    open_d = open_q;
    if (line_fire && !(pixel_fire && last_pixel_i)) begin
      open_d = open_q + 2'd1;
    end else if (!line_fire && pixel_fire && last_pixel_i) begin
      open_d = open_q - 2'd1;
    end
  end

  // Mark the next word of a fresh line as its first pixel
  always_comb begin
    first_d = first_q;
    if (line_fire) begin
      first_d = 1'b1;
    end else if (pixel_fire && open_q == 2'd1) begin
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 2'd0;
      first_q <= 1'b0;
    end else begin
      open_q  <= open_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_fire) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
    end
  end

  // No pixel word without an accepted line
  a_no_stray_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_i |-> (open_q != 2'd0))
    else $error("pixel word shown with no line open");

  // One line at a time: intake closes after a line is taken
  a_one_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_fire |=> !line_ready_i)
    else $error("line accepted while a walk is running");

  // First pixel of a line is its start point
  a_first_is_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_fire && first_q && open_q == 2'd1) |->
      (pixel_x_i == sx_q && pixel_y_i == sy_q))
    else $error("first pixel differs from line start");

  // A stalled pixel word holds
  a_pixel_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_i && !pixel_ready_i) |=>
      (pixel_valid_i && $stable(pixel_x_i) && $stable(pixel_y_i) && $stable(last_pixel_i)))
    else $error("stalled pixel word changed");

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .line_valid_i  (line_i.valid),
  .line_ready_i  (line_i.ready),
  .start_x_i     (line_i.start_x),
  .start_y_i     (line_i.start_y),
  .pixel_valid_i (pixel_o.valid),
  .pixel_ready_i (pixel_o.ready),
  .pixel_x_i     (pixel_o.pixel_x),
  .pixel_y_i     (pixel_o.pixel_y),
  .last_pixel_i  (pixel_o.last_pixel)
);

[tb/line_pixel_generator_core_tb.sv]
`timescale 1ns / 1ps

module line_pixel_generator_core_tb;
  import lpg_pkg::*;

  localparam int unsigned COORD_BITS = COORD_BITS_DEF;
  localparam int          MAX_PIXELS = 1 << COORD_BITS;
  localparam int          COORD_MAX  = (1 << FIELD_W) - 1;
  localparam int          NUM_RANDOM = 208;
  localparam int          HOLD_CYCLES = 200;
  localparam int          HOLD_AT_LINE = 40;
  localparam int          QUIET_FROM = 100;
  localparam int          QUIET_TO = 150;
  localparam int          IDLE_PCT = 9;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [FIELD_W-1:0] start_x;
    logic [FIELD_W-1:0] start_y;
    logic [FIELD_W-1:0] end_x;
    logic [FIELD_W-1:0] end_y;
  } line_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pixel_x;
    logic [FIELD_W-1:0] pixel_y;
    logic               last_pixel;
  } pixel_t;

  // One directed line; when typed is set the line gives a single known pixel
  typedef struct packed {
    logic [FIELD_W-1:0] start_x;
    logic [FIELD_W-1:0] start_y;
    logic [FIELD_W-1:0] end_x;
    logic [FIELD_W-1:0] end_y;
    logic               typed;
    logic [FIELD_W-1:0] pixel_x;
    logic [FIELD_W-1:0] pixel_y;
    logic               last_pixel;
  } line_row_t;

  localparam int NUM_DIRECTED = 22;
  localparam line_row_t LINE_TABLE [NUM_DIRECTED] = '{
    // zero-length lines: one pixel, the start point, marked last
    '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, 6'd0,  6'd0,  1'b1},
    '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63, 1'b1},
    '{6'd42, 6'd21, 6'd42, 6'd21, 1'b1, 6'd42, 6'd21, 1'b1},
    '{6'd21, 6'd42, 6'd21, 6'd42, 1'b1, 6'd21, 6'd42, 1'b1},
    // full-span horizontal and vertical lines, both directions
    '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd63, 6'd63, 6'd0,  6'd63, 1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd0,  6'd0,  6'd0,  6'd63, 1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd63, 6'd63, 6'd63, 6'd0,  1'b0, 6'd0,  6'd0,  1'b0},
    // full-span diagonals
    '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0, 6'd0,  6'd0,  1'b0},
    // steepest and shallowest slopes
    '{6'd0,  6'd0,  6'd1,  6'd63, 1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd0,  6'd0,  6'd63, 6'd1,  1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd63, 6'd63, 6'd62, 6'd0,  1'b0, 6'd0,  6'd0,  1'b0},
    // single steps
    '{6'd5,  6'd5,  6'd6,  6'd5,  1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd10, 6'd10, 6'd9,  6'd11, 1'b0, 6'd0,  6'd0,  1'b0},
    // error term landing exactly on the step thresholds
    '{6'd0,  6'd0,  6'd4,  6'd2,  1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd0,  6'd0,  6'd2,  6'd4,  1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd42, 6'd21, 6'd21, 6'd42, 1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd21, 6'd42, 6'd42, 6'd21, 1'b0, 6'd0,  6'd0,  1'b0},
    '{6'd30, 6'd30, 6'd33, 6'd29, 1'b0, 6'd0,  6'd0,  1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lpg_line_if  line_bus ();
  lpg_pixel_if pixel_bus ();

  line_pixel_generator_core #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .line_i (line_bus),
    .pixel_o(pixel_bus)
  );

  pixel_t pending_pixels[$];
  int     lines_accepted = 0;
  int     pixels_checked = 0;
  int     error_count = 0;
  int     stall_cycles = 0;
  bit     hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  function automatic bit quiet_window();
    return lines_accepted >= QUIET_FROM && lines_accepted < QUIET_TO;
  endfunction

  function automatic logic [FIELD_W-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_MAX[FIELD_W-1:0];
    return v[FIELD_W-1:0];
  endfunction

  // Walk the Bresenham error term and queue every pixel of the line
  function automatic void rasterize_line(input line_t seg);
    int     x, y, xe, ye, dx, dy, step_x, step_y, err, e2, n;
    bit     at_end;
    pixel_t pix;
    x  = int'(seg.start_x) & (MAX_PIXELS - 1);
    y  = int'(seg.start_y) & (MAX_PIXELS - 1);
    xe = int'(seg.end_x) & (MAX_PIXELS - 1);
    ye = int'(seg.end_y) & (MAX_PIXELS - 1);
    dx = xe - x;
    dy = ye - y;
    step_x = (dx > 0) ? 1 : -1;
    step_y = (dy > 0) ? 1 : -1;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    err = dx - dy;
    n = 0;
    while (n < MAX_PIXELS) begin
      at_end = (x == xe) && (y == ye);
      pix.pixel_x    = x[FIELD_W-1:0];
      pix.pixel_y    = y[FIELD_W-1:0];
      pix.last_pixel = at_end;
      pending_pixels.push_back(pix);
      n++;
      if (at_end) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += step_x;
      end
      if (e2 < dx) begin
        err += dx;
        y += step_y;
      end
    end
  endfunction

  // Pick a random line, biased toward short, degenerate and aligned cases
  function automatic line_t pick_line();
    line_t seg;
    int    kind, len;
    kind = int'($urandom_range(0, 99));
    seg.start_x = FIELD_W'($urandom_range(0, COORD_MAX));
    seg.start_y = FIELD_W'($urandom_range(0, COORD_MAX));
    seg.end_x   = FIELD_W'($urandom_range(0, COORD_MAX));
    seg.end_y   = FIELD_W'($urandom_range(0, COORD_MAX));
    len = int'($urandom_range(0, COORD_MAX));
    if (kind < 10) begin
      seg.end_x = seg.start_x;
      seg.end_y = seg.start_y;
    end else if (kind < 40) begin
      seg.end_x = clamp_coord(int'(seg.start_x) + $urandom_range(0, 8) - 4);
      seg.end_y = clamp_coord(int'(seg.start_y) + $urandom_range(0, 8) - 4);
    end else if (kind < 50) begin
      seg.end_y = seg.start_y;
    end else if (kind < 60) begin
      seg.end_x = seg.start_x;
    end else if (kind < 70) begin
      seg.end_x = clamp_coord(int'(seg.start_x) + ($urandom_range(0, 1) ? len : -len));
      seg.end_y = clamp_coord(int'(seg.start_y) + ($urandom_range(0, 1) ? len : -len));
    end else if (kind < 75) begin
      seg.start_x = FIELD_W'($urandom_range(0, 1) ? COORD_MAX : 0);
      seg.start_y = FIELD_W'($urandom_range(0, 1) ? COORD_MAX : 0);
      seg.end_x   = FIELD_W'($urandom_range(0, 1) ? COORD_MAX : 0);
      seg.end_y   = FIELD_W'($urandom_range(0, 1) ? COORD_MAX : 0);
    end
    return seg;
  endfunction

  // Offer one line word after a random gap; queue its pixels once accepted
  task automatic send_line(input line_t seg, input bit typed, input pixel_t known);
    while (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
      line_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    line_bus.valid   <= 1'b1;
    line_bus.start_x <= seg.start_x;
    line_bus.start_y <= seg.start_y;
    line_bus.end_x   <= seg.end_x;
    line_bus.end_y   <= seg.end_y;
    @(posedge clk_i);
    while (!line_bus.ready) @(posedge clk_i);
    if (typed) pending_pixels.push_back(known);
    else rasterize_line(seg);
    lines_accepted++;
  endtask

  // Reset, directed table, random lines, then drain and report
  initial begin : line_source
    line_t     seg;
    pixel_t    known;
    line_row_t row;
    rst_ni           <= 1'b0;
    line_bus.valid   <= 1'b0;
    line_bus.start_x <= '0;
    line_bus.start_y <= '0;
    line_bus.end_x   <= '0;
    line_bus.end_y   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = LINE_TABLE[i];
      seg = '{row.start_x, row.start_y, row.end_x, row.end_y};
      known = '{row.pixel_x, row.pixel_y, row.last_pixel};
      send_line(seg, row.typed, known);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_line(pick_line(), 1'b0, '0);
    end
    line_bus.valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Drew %0d lines (%0d directed, %0d random), checked %0d pixel words,",
             lines_accepted, NUM_DIRECTED, NUM_RANDOM, pixels_checked);
    $display("with random idling on both sides and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Drive pixel ready: random stalls, one long hold-off, a quiet window
  initial begin : pixel_sink
    pixel_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && lines_accepted >= HOLD_AT_LINE) begin
        pixel_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      pixel_bus.ready <= quiet_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each accepted pixel word with the oldest expectation
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pixel_bus.valid && pixel_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        error_count++;
        $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                 pixel_bus.pixel_x, pixel_bus.pixel_y, pixel_bus.last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (pixel_bus.pixel_x !== want.pixel_x) begin
          error_count++;
          $display("%0t: pixel_x expected %0d, got %0d", $time,
                   want.pixel_x, pixel_bus.pixel_x);
        end
        if (pixel_bus.pixel_y !== want.pixel_y) begin
          error_count++;
          $display("%0t: pixel_y expected %0d, got %0d", $time,
                   want.pixel_y, pixel_bus.pixel_y);
        end
        if (pixel_bus.last_pixel !== want.last_pixel) begin
          error_count++;
          $display("%0t: last_pixel expected %0b, got %0b", $time,
                   want.last_pixel, pixel_bus.last_pixel);
        end
      end
    end
  end

  // Abort when no word moves on either channel for too long
  always @(posedge clk_i) begin
    if ((line_bus.valid && line_bus.ready) || (pixel_bus.valid && pixel_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d pixels still expected", $time,
               STALL_LIMIT, pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
